FILE: sv/urbr_pkg.sv
// Shared types and constants for the UART burst receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package urbr_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SAMPLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE  = 2'd2;

  // Parity modes; any other code acts as even
  localparam logic [1:0] PARITY_NONE = 2'd0;
  localparam logic [1:0] PARITY_ODD  = 2'd1;

  // Result kinds
  localparam logic [2:0] KIND_BYTE    = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_TIMEOUT = 3'd2;
  localparam logic [2:0] KIND_PARITY  = 3'd3;
  localparam logic [2:0] KIND_STOP    = 3'd4;

  // Frame bit positions
  localparam logic [3:0] BIT_PARITY = 4'd8;
  localparam logic [3:0] BIT_STOP_P = 4'd9;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] bit_period;
    logic [PERIOD_W-1:0] first_sample_delay;
    logic [1:0]          parity_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [2:0] kind;
  } result_t;

endpackage

FILE: sv/urbr_core.sv
// Frame state machine and per-tick update of the UART burst receiver.
// Depends on urbr_pkg.
`timescale 1ns / 1ps

module urbr_core #(
  parameter int unsigned BURST_BYTES   = 257,
  parameter int unsigned IDLE_GAP_BITS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  urbr_pkg::cfg_t   cfg,
  input  logic             item_level,   // registered tick level
  input  logic             fire,         // consume the registered tick
  output logic             produce,      // this tick gives a result
  output logic             res_valid,
  output urbr_pkg::result_t res
);
  import urbr_pkg::*;

  localparam int unsigned TICK_W  = PERIOD_W + $clog2(IDLE_GAP_BITS + 1);
  localparam int unsigned BURST_W = $clog2(BURST_BYTES + 1);

  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [3:0]          bidx_r, bidx_nxt;
  logic [7:0]          shift_r, shift_nxt;
  logic                par_r, par_nxt;
  logic [BURST_W-1:0]  burst_r, burst_nxt;
  logic                prev_r;

  logic [TICK_W-1:0]   period;
  logic [TICK_W-1:0]   gap_ticks;
  logic [TICK_W-1:0]   tick_dec;
  logic [BURST_W-1:0]  burst_inc;
  logic                start;
  logic                do_sample;
  // operands of the sample step (cleared when a burst starts)
  logic [3:0]          s_bidx;
  logic [7:0]          s_shift;
  logic                s_par;
  logic [BURST_W-1:0]  s_burst;

  assign period    = (cfg.bit_period == '0) ? TICK_W'(1) : TICK_W'(cfg.bit_period);
  assign gap_ticks = TICK_W'(IDLE_GAP_BITS) * period;
  assign tick_dec  = (tick_r != '0) ? tick_r - TICK_W'(1) : '0;
  assign start     = (phase_r == PH_IDLE) && prev_r && !item_level;

  always_comb begin
    s_bidx  = start ? 4'd0 : bidx_r;
    s_shift = start ? 8'd0 : shift_r;
    s_par   = start ? 1'b0 : par_r;
    s_burst = start ? '0   : burst_r;
    burst_inc = s_burst + BURST_W'(1);
  end

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bidx_nxt  = bidx_r;
    shift_nxt = shift_r;
    par_nxt   = par_r;
    burst_nxt = burst_r;
    produce   = 1'b0;
    res       = '{rx_byte: 8'd0, kind: KIND_BYTE};
    do_sample = 1'b0;

    case (phase_r)
      PH_DATA: begin
        tick_nxt = tick_dec;
        if (tick_dec == '0) do_sample = 1'b1;
      end
      PH_GAP: begin
        tick_nxt = tick_dec;
        if (tick_dec == '0) begin
          phase_nxt = PH_IDLE;
          burst_nxt = '0;
          bidx_nxt  = 4'd0;
          shift_nxt = 8'd0;
          par_nxt   = 1'b0;
          produce   = 1'b1;
          res.kind  = KIND_TIMEOUT;
        end else if (!item_level) begin
          phase_nxt = PH_DATA;
          bidx_nxt  = 4'd0;
          shift_nxt = 8'd0;
          par_nxt   = 1'b0;
          tick_nxt  = period;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (start) begin
          phase_nxt = PH_DATA;
          burst_nxt = '0;
          bidx_nxt  = 4'd0;
          shift_nxt = 8'd0;
          par_nxt   = 1'b0;
          tick_nxt  = TICK_W'(cfg.first_sample_delay);
          if (cfg.first_sample_delay == '0) do_sample = 1'b1;
        end
      end
    endcase

    if (do_sample) begin
      if (s_bidx < BIT_PARITY) begin
        shift_nxt = s_shift;
        shift_nxt[s_bidx[2:0]] = item_level;
        par_nxt   = s_par ^ item_level;
        bidx_nxt  = s_bidx + 4'd1;
        tick_nxt  = period;
      end else if (s_bidx == BIT_PARITY && cfg.parity_mode != PARITY_NONE) begin
        par_nxt  = s_par ^ item_level;
        bidx_nxt = BIT_STOP_P;
        tick_nxt = period;
      end else begin
        // stop bit: parity checked before framing
        produce   = 1'b1;
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
        burst_nxt = '0;
        bidx_nxt  = 4'd0;
        shift_nxt = 8'd0;
        par_nxt   = 1'b0;
        if (s_bidx == BIT_STOP_P && ((cfg.parity_mode == PARITY_ODD) != s_par)) begin
          res.kind = KIND_PARITY;
        end else if (!item_level) begin
          res.kind = KIND_STOP;
        end else if (32'(burst_inc) >= BURST_BYTES) begin
          res = '{rx_byte: s_shift, kind: KIND_FULL};
        end else begin
          res       = '{rx_byte: s_shift, kind: KIND_BYTE};
          burst_nxt = burst_inc;
          phase_nxt = PH_GAP;
          tick_nxt  = gap_ticks;
        end
      end
    end
  end

  assign res_valid = fire && produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bidx_r  <= 4'd0;
      shift_r <= 8'd0;
      par_r   <= 1'b0;
      burst_r <= '0;
      prev_r  <= 1'b1;
    end else if (fire) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bidx_r  <= bidx_nxt;
      shift_r <= shift_nxt;
      par_r   <= par_nxt;
      burst_r <= burst_nxt;
      prev_r  <= item_level;
    end
  end

endmodule

FILE: sv/urbr_out.sv
// Result register of the UART burst receiver, drives the out_ channel.
// Depends on urbr_pkg.
`timescale 1ns / 1ps

module urbr_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  urbr_pkg::result_t res,
  output logic              free,       // can take a result this cycle
  output logic              out_valid,
  input  logic              out_stall,
  output urbr_pkg::result_t out_res
);
  import urbr_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) valid_nxt = 1'b1;
    else if (valid_r && !out_stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) res_r <= res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: sv/uart_rx_burst_receiver.sv
// Top level of the UART burst receiver: input register, config registers,
// frame logic and result register. Depends on urbr_pkg, urbr_core, urbr_out.
`timescale 1ns / 1ps

// Usage
//   in_ channel: one transfer per timer tick, carrying the sampled line level
//   in in_rx_level. A transfer completes when in_valid is high and in_stall low.
//   out_ channel: one transfer per received byte or burst end, with
//   out_rx_byte and out_kind (byte, byte filling the burst, idle timeout,
//   parity error, stop bit error). Completes when out_valid high, out_stall low.
//   cfg_ channel: register writes (bit period, first-sample delay, parity
//   mode) on cfg_valid & cfg_ready; cfg_ready is always high. Write only
//   while the receiver is idle.
// Timing
//   One tick per clock cycle sustained while out_ does not hold back a result.
//   A tick lands in the input register at its transfer and is processed from
//   there; its result, if any, is offered on out_ from the result register.
// Reset (rst_n, synchronous, active low)
//   Registers go to defaults (bit period 208, delay 208, no parity), the
//   receiver idles with the line assumed high, and both channels empty.
// Backpressure
//   A stalled result is held in the output register. Ticks that give no
//   result keep flowing; a tick that gives a result waits in the input
//   register until the output register frees, and in_stall rises meanwhile.
module uart_rx_burst_receiver #(
  parameter int unsigned BURST_BYTES   = 257,
  parameter int unsigned IDLE_GAP_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_rx_level,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_rx_byte,
  output logic [2:0]                        out_kind,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [urbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [urbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import urbr_pkg::*;

  cfg_t    cfg_r;
  logic    s1_valid_r, s1_valid_nxt;
  logic    s1_level_r;
  logic    accept;
  logic    fire;
  logic    produce;
  logic    res_valid;
  result_t res;
  logic    out_free;
  result_t out_res;

  // Config registers; index 3 is ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_period         <= PERIOD_W'(208);
      cfg_r.first_sample_delay <= PERIOD_W'(208);
      cfg_r.parity_mode        <= PARITY_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIT_PERIOD:   cfg_r.bit_period         <= cfg_data;
        CFG_FIRST_SAMPLE: cfg_r.first_sample_delay <= cfg_data;
        CFG_PARITY_MODE:  cfg_r.parity_mode        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Input register: the tick is consumed once its result has a place to go
  assign fire     = s1_valid_r && (!produce || out_free);
  assign in_stall = s1_valid_r && !fire;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) s1_valid_nxt = 1'b1;
    else if (fire) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_level_r <= in_rx_level;
  end

  urbr_core #(
    .BURST_BYTES   (BURST_BYTES),
    .IDLE_GAP_BITS (IDLE_GAP_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_level (s1_level_r),
    .fire       (fire),
    .produce    (produce),
    .res_valid  (res_valid),
    .res        (res)
  );

  urbr_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_rx_byte = out_res.rx_byte;
  assign out_kind    = out_res.kind;

endmodule

FILE: tb/uart_rx_burst_receiver_test.sv
// Self-checking testbench for uart_rx_burst_receiver: line-level ticks in,
// received bytes and burst ends out, predicted by a scoreboard class.
// Depends on urbr_pkg and the uart_rx_burst_receiver RTL.
`timescale 1ns / 1ps

module uart_rx_burst_receiver_test;
  import urbr_pkg::*;

  localparam int unsigned BURST_LEN      = 257;
  localparam int unsigned GAP_BITS       = 10;
  // Extra wait after a drain, leaving a margin behind the last result.
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned LONG_HOLD      = 600;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // Random rounds stop once this many ticks went in; the last round overshoots a bit.
  localparam int unsigned TICK_TARGET    = 880;

  // Parity codes the package leaves implicit; code 3 behaves as even.
  localparam logic [1:0] PARITY_EVEN = 2'd2;
  localparam logic [1:0] PARITY_ALT  = 2'd3;
  // Index with no register behind it; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Scoreboard: shadows the receiver frame logic, queues expected results
  // per accepted tick and compares them with what comes out.
  class rx_scoreboard;
    logic [15:0] bit_period;
    logic [15:0] first_delay;
    logic [1:0]  parity_mode;
    phase_t      phase;
    logic [19:0] tick_count;
    logic [3:0]  bit_index;
    logic [7:0]  shift_byte;
    logic        ones_parity;
    logic [8:0]  burst_count;
    logic        prev_level;
    result_t     expected_q[$];
    int unsigned errors;
    int unsigned ticks;

    function new();
      bit_period   = 16'd208;
      first_delay  = 16'd208;
      parity_mode  = PARITY_NONE;
      phase        = PH_IDLE;
      tick_count   = '0;
      burst_count  = '0;
      prev_level   = 1'b1;
      errors       = 0;
      ticks        = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      bit_index   = '0;
      shift_byte  = '0;
      ones_parity = 1'b0;
    endfunction

    function void close_burst();
      phase       = PH_IDLE;
      tick_count  = '0;
      burst_count = '0;
      clear_frame();
    endfunction

    // Zero bit period counts as one tick.
    function logic [19:0] eff_period();
      return (bit_period == 16'd0) ? 20'd1 : 20'(bit_period);
    endfunction

    function void push_result(logic [7:0] rx_byte, logic [2:0] kind);
      result_t r;
      r.rx_byte = rx_byte;
      r.kind    = kind;
      expected_q.push_back(r);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BIT_PERIOD:   bit_period  = data;
        CFG_FIRST_SAMPLE: first_delay = data;
        CFG_PARITY_MODE:  parity_mode = data[1:0];
        default: ;
      endcase
    endfunction

    // One bit sample: data, then optional parity, then stop.
    function void sample_bit(logic level);
      logic [7:0] data;
      if (bit_index < 4'd8) begin
        shift_byte[bit_index[2:0]] = level;
        ones_parity = ones_parity ^ level;
        bit_index   = bit_index + 4'd1;
        tick_count  = eff_period();
      end else if (bit_index == BIT_PARITY && parity_mode != PARITY_NONE) begin
        ones_parity = ones_parity ^ level;
        bit_index   = BIT_STOP_P;
        tick_count  = eff_period();
      end else begin
        data = shift_byte;
        // parity wins over a bad stop bit
        if (bit_index == BIT_STOP_P && ones_parity != (parity_mode == PARITY_ODD)) begin
          close_burst();
          push_result(8'h00, KIND_PARITY);
        end else if (!level) begin
          close_burst();
          push_result(8'h00, KIND_STOP);
        end else begin
          burst_count = burst_count + 9'd1;
          if (burst_count >= BURST_LEN) begin
            close_burst();
            push_result(data, KIND_FULL);
          end else begin
            clear_frame();
            phase      = PH_GAP;
            tick_count = 20'(GAP_BITS * eff_period());
            push_result(data, KIND_BYTE);
          end
        end
      end
    endfunction

    function void note_tick(logic level);
      logic prev;
      prev       = prev_level;
      prev_level = level;
      ticks++;
      case (phase)
        PH_DATA: begin
          if (tick_count != 0) tick_count = tick_count - 20'd1;
          if (tick_count == 0) sample_bit(level);
        end
        PH_GAP: begin
          if (tick_count != 0) tick_count = tick_count - 20'd1;
          if (tick_count == 0) begin
            close_burst();
            push_result(8'h00, KIND_TIMEOUT);
          end else if (!level) begin
            phase = PH_DATA;
            clear_frame();
            tick_count = eff_period();
          end
        end
        default: begin
          phase = PH_IDLE;
          if (prev && !level) begin
            phase       = PH_DATA;
            burst_count = '0;
            clear_frame();
            tick_count  = 20'(first_delay);
            if (tick_count == 0) sample_bit(level);
          end
        end
      endcase
    endfunction

    function void check_result(logic [7:0] rx_byte, logic [2:0] kind);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %02h kind %0d",
                 $time, rx_byte, kind);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (rx_byte !== want.rx_byte) begin
        $display("%0t: rx_byte mismatch, expected %02h, got %02h",
                 $time, want.rx_byte, rx_byte);
        errors++;
      end
      if (kind !== want.kind) begin
        $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, kind);
        errors++;
      end
    endfunction

    function bit is_idle();
      return phase == PH_IDLE;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_rx_level;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_rx_byte;
  logic [2:0]            out_kind;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rx_scoreboard sb;

  // Stimulus-side copy of the line set-up, used to shape frames only.
  logic [15:0] line_period;
  logic [15:0] line_delay;
  logic [1:0]  line_parity;
  logic        last_level;
  // Idling switches: sender gaps between ticks, receiver stalls per result.
  bit          gap_en;
  bit          stall_en;
  // Bumped by the stimulus to ask the result sink for one long hold-off.
  int unsigned hold_asked;
  int unsigned quiet_cycles;

  uart_rx_burst_receiver #(
    .BURST_BYTES  (BURST_LEN),
    .IDLE_GAP_BITS(GAP_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_level(in_rx_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rx_byte(out_rx_byte),
    .out_kind   (out_kind),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a run that stops making transfers for too long is dead.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result sink. Draws a stall before each result so the hold-off lands on
  // every phase of the frame logic; on request one draw becomes a long hold
  // so the output register fills and the block backs up onto in_stall.
  initial begin : result_sink
    int unsigned hold_n;
    int unsigned hold_done;
    hold_done = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold_n = stall_en ? $urandom_range(0, 14) : 0;
      if (hold_asked != hold_done) begin
        hold_done++;
        hold_n = LONG_HOLD;
      end
      if (hold_n > 0) begin
        out_stall <= 1'b1;
        repeat (hold_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_rx_byte, out_kind);
    end
  end

  // One tick transfer. in_valid stays high after the transfer so the next
  // call can follow in the same cycle; callers that pause must lower it.
  task automatic send_tick(input logic level);
    int unsigned wait_n;
    wait_n = gap_en ? $urandom_range(0, 14) : 0;
    if (wait_n > 0) begin
      in_valid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_rx_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(level);
    last_level = level;
  endtask

  task automatic idle_ticks(input int unsigned n);
    repeat (n) send_tick(1'b1);
  endtask

  // n ticks of one bit; the first tick is the sample point and stays clean,
  // later ones may glitch when noisy (the block must ignore them).
  task automatic hold_level(input logic level, input int unsigned n, input bit noisy);
    for (int unsigned i = 0; i < n; i++) begin
      send_tick((i > 0 && noisy && $urandom_range(0, 3) == 0) ? ~level : level);
    end
  endtask

  // One frame, laid out so each sample tick carries the intended bit.
  // A first frame starts on a falling edge and uses the first-sample delay;
  // a follow-on frame starts from the gap and uses one bit period.
  task automatic send_frame(input bit first, input logic [7:0] data, input bit bad_parity,
                            input logic stop_level, input bit noisy);
    int unsigned per;
    int unsigned lead;
    logic [7:0]  bits8;
    logic        par_bit;
    per  = (line_period == 16'd0) ? 1 : line_period;
    lead = first ? line_delay : per;
    bits8 = data;
    // with no lead, bit 0 is sampled on the (low) edge tick itself
    if (lead == 0) bits8[0] = 1'b0;
    if (first && !last_level) send_tick(1'b1);
    if (lead > 0) hold_level(1'b0, lead, noisy);
    for (int i = 0; i < 8; i++) hold_level(bits8[i], per, noisy);
    if (line_parity != PARITY_NONE) begin
      par_bit = (line_parity == PARITY_ODD) ? ~(^bits8) : ^bits8;
      hold_level(par_bit ^ bad_parity, per, noisy);
    end
    // stop sample: one clean tick, the gap watch starts right after it
    send_tick(stop_level);
  endtask

  // Run the line high until the receiver is idle and every result is in.
  task automatic drain();
    while (!sb.is_idle()) send_tick(1'b1);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Registers only change with the receiver idle and the pipe empty.
  task automatic configure(input logic [15:0] period, input logic [15:0] delay,
                           input logic [1:0] parity);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(CFG_BIT_PERIOD, period);
    cfg_write(CFG_FIRST_SAMPLE, delay);
    // upper data bits are don't-care for the parity register
    cfg_write(CFG_PARITY_MODE, {14'($urandom), parity});
    cfg_valid   <= 1'b0;
    line_period = period;
    line_delay  = delay;
    line_parity = parity;
  endtask

  initial begin : stimulus
    int unsigned per;
    int unsigned n_bytes;
    int unsigned round;
    sb           = new();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_rx_level <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_BIT_PERIOD;
    cfg_data    <= '0;
    line_period  = 16'd208;
    line_delay   = 16'd208;
    line_parity  = PARITY_NONE;
    last_level   = 1'b1;
    gap_en       = 1'b0;
    stall_en     = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset set-up: the line idles high back to back and nothing comes out.
    idle_ticks(12);

    gap_en = 1'b1;
    // Zero bit period acts as one; zero lead samples bit 0 on the edge tick.
    configure(16'd0, 16'd0, PARITY_NONE);
    send_frame(1'b1, 8'h00, 1'b0, 1'b1, 1'b0);
    // next start bit right after the stop sample
    send_frame(1'b0, 8'hFE, 1'b0, 1'b1, 1'b0);
    // latest start still inside the gap
    idle_ticks(8);
    send_frame(1'b0, 8'h7E, 1'b0, 1'b1, 1'b1);
    // low on the very tick the gap runs out: timeout, and no edge follows
    idle_ticks(9);
    send_tick(1'b0);
    send_tick(1'b0);

    // Odd parity: good byte, then parity and stop both bad (parity reported),
    // then a fresh burst with only the stop bit bad.
    configure(16'd1, 16'd1, PARITY_ODD);
    send_frame(1'b1, 8'hFF, 1'b0, 1'b1, 1'b0);
    send_frame(1'b0, 8'h01, 1'b1, 1'b0, 1'b0);
    send_frame(1'b1, 8'h80, 1'b0, 1'b0, 1'b0);

    configure(16'd2, 16'd3, PARITY_EVEN);
    send_frame(1'b1, 8'h3C, 1'b0, 1'b1, 1'b1);
    send_frame(1'b0, 8'hC3, 1'b1, 1'b1, 1'b1);

    // Parity code 3 behaves as even.
    configure(16'd1, 16'd2, PARITY_ALT);
    send_frame(1'b1, 8'h5A, 1'b0, 1'b1, 1'b0);
    send_frame(1'b0, 8'h96, 1'b1, 1'b1, 1'b0);

    // All-ones registers and the unused index; line stays idle.
    configure(16'hFFFF, 16'hFFFF, PARITY_ALT);
    idle_ticks(20);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(CFG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;

    // Random part: short periods, random set-ups, mostly well-formed bursts
    // with random data, some bad parity/stop bits, glitches and plain noise.
    round = 0;
    while (sb.ticks < TICK_TARGET) begin
      configure(16'($urandom_range(0, 3)), 16'($urandom_range(0, 6)),
                2'($urandom_range(0, 3)));
      per = (line_period == 16'd0) ? 1 : line_period;
      // two rounds push back hard with the sender streaming
      if (round == 1 || round == 3) begin
        gap_en = 1'b0;
        hold_asked++;
      end else begin
        gap_en = ($urandom_range(0, 3) != 0);
      end
      stall_en = ($urandom_range(0, 3) != 0);
      repeat (2) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 20)) send_tick(1'($urandom));
        end else begin
          n_bytes = $urandom_range(1, 3);
          for (int b = 0; b < n_bytes; b++) begin
            send_frame(sb.is_idle(), 8'($urandom), ($urandom_range(0, 9) == 0),
                       ($urandom_range(0, 9) != 0), 1'($urandom));
            if (!sb.is_idle() && b + 1 < n_bytes) begin
              idle_ticks($urandom_range(0, GAP_BITS * per - 2));
            end
          end
          if (!sb.is_idle()) idle_ticks(GAP_BITS * per + $urandom_range(0, 2));
        end
      end
      round++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
